### rtl/fcd_pkg.sv
`timescale 1ns / 1ps

package fcd_pkg;

  // stick fraction bits (Q1.14 sticks and outputs)
  localparam int STICK_FRAC_BITS = 14;

  localparam int FIELD_W   = 16;
  localparam int TRIG_W    = 17;               // Q1.15 signed, +1.0 included
  localparam int TERM_W    = TRIG_W + 2;       // sum of two trig terms, negated
  localparam int ACC_W     = 34;               // holds +/-2^31 with margin
  localparam int MUL_STEPS = FIELD_W;          // one multiplier bit per cycle
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

  localparam int DIVISOR   = 100;
  localparam int REM_W     = $clog2(DIVISOR);
  localparam int HUND_W    = 9;                // forward in hundredths, |x| <= 400
  localparam int DIV_W     = HUND_W + STICK_FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int TRIG_FRAC = 15;               // Q1.15 trig and slow scale
  localparam int FWD_SHIFT = STICK_FRAC_BITS + TRIG_FRAC;
  localparam int PROD_W    = ACC_W + 7;        // |P| * 100

  localparam int DEG_W        = 9;
  localparam int ANGLE_W      = DEG_W + 1;
  localparam int DEG_QUARTER  = 90;
  localparam int DEG_HALF     = 180;
  localparam int DEG_3QUARTER = 270;
  localparam int DEG_FULL     = 360;
  localparam int HDG_MAX      = 35999;

  localparam int POS_MAX = 2 ** (FIELD_W - 1) - 1;
  localparam int NEG_MAG = 2 ** (FIELD_W - 1);

  localparam logic [FIELD_W-1:0] SLOW_SCALE_RST = 16'd16384;

  // request kind carried in req_type
  typedef enum logic {
    REQ_DRIVE   = 1'b0,
    REQ_CAPTURE = 1'b1
  } req_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_HDG,
    ST_ANGLE,
    ST_LUT,
    ST_ROT,
    ST_FWD,
    ST_HUND,
    ST_DIV_FWD,
    ST_FWD_FIN,
    ST_SLOW,
    ST_SLOW_FIN,
    ST_DONE
  } fcd_state_t;

  typedef enum logic {
    MAC_ROT,
    MAC_SCALE
  } mac_mode_t;

  typedef struct packed {
    logic      start;
    mac_mode_t mode;
  } mac_ctl_t;

  // sin(k deg), k = 0..90, Q1.15 rounded
  localparam logic [FIELD_W-1:0] SINE_Q15 [0:DEG_QUARTER] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  // sine of d degrees, d in 0..359, quarter-wave folded
  function automatic logic signed [TRIG_W-1:0] sin_q15(input logic [DEG_W-1:0] d);
    logic [DEG_W-1:0]        idx;
    logic                    neg;
    logic signed [TRIG_W-1:0] mag;
    if (d <= DEG_W'(DEG_QUARTER)) begin
      idx = d;
      neg = 1'b0;
    end else if (d <= DEG_W'(DEG_HALF)) begin
      idx = DEG_W'(DEG_HALF) - d;
      neg = 1'b0;
    end else if (d <= DEG_W'(DEG_3QUARTER)) begin
      idx = d - DEG_W'(DEG_HALF);
      neg = 1'b1;
    end else begin
      idx = DEG_W'(DEG_FULL) - d;
      neg = 1'b1;
    end
    mag = signed'({1'b0, SINE_Q15[idx[6:0]]});
    return neg ? -mag : mag;
  endfunction

  // saturate sign + magnitude to a 16-bit signed value
  function automatic logic signed [FIELD_W-1:0] sat_mag(input logic neg,
                                                        input logic [ACC_W-1:0] m);
    logic [FIELD_W-1:0] low;
    low = m[FIELD_W-1:0];
    if (!neg) begin
      return (m > ACC_W'(POS_MAX)) ? FIELD_W'(POS_MAX) : signed'(low);
    end else begin
      return (m > ACC_W'(NEG_MAG)) ? signed'(FIELD_W'(NEG_MAG)) : signed'(~low + 1'b1);
    end
  endfunction

  // divide by 2^15 truncating toward zero, then saturate
  function automatic logic signed [FIELD_W-1:0] shr0_sat(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic             neg;
    neg = v[ACC_W-1];
    mag = neg ? (~v + 1'b1) : v;
    return sat_mag(neg, ACC_W'(mag[ACC_W-1:TRIG_FRAC]));
  endfunction

endpackage

### rtl/fcd_in_if.sv
`timescale 1ns / 1ps

interface fcd_in_if import fcd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [FIELD_W-1:0]        heading_cdeg;
  logic signed [FIELD_W-1:0] stick_forward;
  logic signed [FIELD_W-1:0] stick_strafe;
  logic signed [FIELD_W-1:0] stick_turn;
  logic                      field_centric;
  logic                      field_centric_hold;
  logic                      slow_mode;

  modport source (
    output valid, req_type, heading_cdeg, stick_forward, stick_strafe, stick_turn,
           field_centric, field_centric_hold, slow_mode,
    input  ready
  );

  modport sink (
    input  valid, req_type, heading_cdeg, stick_forward, stick_strafe, stick_turn,
           field_centric, field_centric_hold, slow_mode,
    output ready
  );
endinterface

### rtl/fcd_out_if.sv
`timescale 1ns / 1ps

interface fcd_out_if import fcd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] out_forward;
  logic signed [FIELD_W-1:0] out_strafe;
  logic signed [FIELD_W-1:0] out_turn;

  modport source (
    output valid, out_forward, out_strafe, out_turn,
    input  ready
  );

  modport sink (
    input  valid, out_forward, out_strafe, out_turn,
    output ready
  );
endinterface

### rtl/fcd_div100.sv
`timescale 1ns / 1ps

// Restoring divider by 100, one quotient bit per cycle, MSB first.
module fcd_div100 import fcd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic             last,
  output logic [DIV_W-1:0] quot,
  output logic [REM_W-1:0] rem
);

  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [REM_W:0]       trial;
  logic                 ge;

  always_comb begin
    trial   = {rem_r, dvd_r[DIV_W-1]};
    ge      = trial >= (REM_W + 1)'(DIVISOR);
    rem_nxt = ge ? REM_W'(trial - (REM_W + 1)'(DIVISOR)) : trial[REM_W-1:0];
    dvd_nxt = {dvd_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign last = (cnt_r == DIV_CNT_W'(1));
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

### rtl/fcd_serial_mac.sv
`timescale 1ns / 1ps

// Three-lane bit-serial multiply-accumulate, multiplier MSB first.
// MAC_ROT:   lane0 = a*cos + b*sin, lane1 = b*cos - a*sin (a, b signed)
// MAC_SCALE: lane k = val_k * a (a unsigned)
module fcd_serial_mac import fcd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mac_ctl_t                  ctl,
  input  logic [FIELD_W-1:0]        mplr_a,
  input  logic [FIELD_W-1:0]        mplr_b,
  input  logic signed [TRIG_W-1:0]  cos_v,
  input  logic signed [TRIG_W-1:0]  sin_v,
  input  logic signed [FIELD_W-1:0] val0,
  input  logic signed [FIELD_W-1:0] val1,
  input  logic signed [FIELD_W-1:0] val2,
  output logic                      last,
  output logic signed [ACC_W-1:0]   acc0,
  output logic signed [ACC_W-1:0]   acc1,
  output logic signed [ACC_W-1:0]   acc2
);

  logic [FIELD_W-1:0]       a_r, b_r;
  mac_mode_t                mode_r;
  logic [MUL_CNT_W-1:0]     cnt_r;
  logic signed [ACC_W-1:0]  acc_r   [3];
  logic signed [ACC_W-1:0]  acc_nxt [3];
  logic signed [TERM_W-1:0] term    [3];
  logic signed [TERM_W-1:0] ca, na, cb, nb;
  logic                     bit_a, bit_b, msb_step;

  always_comb begin
    bit_a    = a_r[FIELD_W-1];
    bit_b    = b_r[FIELD_W-1];
    msb_step = (cnt_r == MUL_CNT_W'(MUL_STEPS));
    ca = bit_a ? TERM_W'(cos_v) : '0;
    na = bit_a ? TERM_W'(sin_v) : '0;
    cb = bit_b ? TERM_W'(cos_v) : '0;
    nb = bit_b ? TERM_W'(sin_v) : '0;
    if (mode_r == MAC_ROT) begin
      term[0] = ca + nb;
      term[1] = cb - na;
      term[2] = '0;
      // sign bit of a two's complement multiplier weighs negative
      if (msb_step) begin
        term[0] = -term[0];
        term[1] = -term[1];
      end
    end else begin
      term[0] = bit_a ? TERM_W'(val0) : '0;
      term[1] = bit_a ? TERM_W'(val1) : '0;
      term[2] = bit_a ? TERM_W'(val2) : '0;
    end
    for (int k = 0; k < 3; k++) begin
      acc_nxt[k] = (acc_r[k] <<< 1) + ACC_W'(term[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.start) begin
      cnt_r <= MUL_CNT_W'(MUL_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r    <= mplr_a;
      b_r    <= mplr_b;
      mode_r <= ctl.mode;
      for (int k = 0; k < 3; k++) acc_r[k] <= '0;
    end else if (cnt_r != '0) begin
      a_r <= {a_r[FIELD_W-2:0], 1'b0};
      b_r <= {b_r[FIELD_W-2:0], 1'b0};
      for (int k = 0; k < 3; k++) acc_r[k] <= acc_nxt[k];
    end
  end

  assign last = (cnt_r == MUL_CNT_W'(1));
  assign acc0 = acc_r[0];
  assign acc1 = acc_r[1];
  assign acc2 = acc_r[2];

endmodule

### rtl/field_centric_drive_rotator.sv
`timescale 1ns / 1ps

// Field-centric drive transform. A capture beat (req_type 1) stores the
// whole-degree heading as the zero offset and returns nothing. A drive beat
// returns one result: in field-centric mode (field_centric_hold low) the
// forward/strafe sticks are rotated by minus the relative heading (forward
// quantized to hundredths), otherwise they pass through; slow mode then
// scales all three by slow_scale. One item is in work at a time; the result
// register lets the next item be taken while a result still waits. Work is
// bit serial: a divide-by-100 unit and a three-lane serial multiplier set the
// rate. A drive can also wait for the output side.
module field_centric_drive_rotator import fcd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  fcd_in_if.sink             in_ch,
  fcd_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_data
);

  fcd_state_t state_r, state_nxt;

  // control strobes
  logic     in_ready, in_acc, fc_in;
  logic     div_start, out_load;
  mac_ctl_t mac_ctl;

  // config and persistent state
  logic [FIELD_W-1:0] slow_scale_r;
  logic [DEG_W-1:0]   offset_r;

  // item and working registers
  logic                      req_r, slow_r;
  logic signed [FIELD_W-1:0] res0_r, res1_r, res2_r;
  logic [DEG_W-1:0]          deg_r;
  logic signed [TRIG_W-1:0]  cos_r, sin_r;
  logic                      p_neg_r;
  logic [ACC_W-1:0]          p_mag_r;

  // output register
  logic                      out_valid_r;
  logic signed [FIELD_W-1:0] out_fwd_r, out_str_r, out_trn_r;

  // unit wires
  logic                    div_last, mac_last;
  logic [DIV_W-1:0]        div_dvd, div_quot;
  logic [REM_W-1:0]        div_rem;
  logic signed [ACC_W-1:0] acc0, acc1, acc2;

  // datapath helpers
  logic [FIELD_W-1:0] cd_sat;
  logic [ANGLE_W-1:0] rel;
  logic [DEG_W-1:0]   hdg_deg, deg_nxt, cos_idx;
  logic               wrap_up;
  logic [PROD_W-1:0]  prod;
  logic [HUND_W-1:0]  hund;
  logic [ACC_W-1:0]   p_mag;
  logic [FIELD_W-1:0] mplr_a;

  assign in_acc = in_ch.valid && in_ready;
  assign fc_in  = in_ch.field_centric && !in_ch.field_centric_hold;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == REQ_CAPTURE || fc_in) state_nxt = ST_DIV_HDG;
          else if (in_ch.slow_mode)                   state_nxt = ST_SLOW;
          else                                        state_nxt = ST_DONE;
        end
      end
      ST_DIV_HDG:  if (div_last) state_nxt = ST_ANGLE;
      ST_ANGLE:    state_nxt = (req_r == REQ_CAPTURE) ? ST_IDLE : ST_LUT;
      ST_LUT:      state_nxt = ST_ROT;
      ST_ROT:      if (mac_last) state_nxt = ST_FWD;
      ST_FWD:      state_nxt = ST_HUND;
      ST_HUND:     state_nxt = ST_DIV_FWD;
      ST_DIV_FWD:  if (div_last) state_nxt = ST_FWD_FIN;
      ST_FWD_FIN:  state_nxt = slow_r ? ST_SLOW : ST_DONE;
      ST_SLOW:     if (mac_last) state_nxt = ST_SLOW_FIN;
      ST_SLOW_FIN: state_nxt = ST_DONE;
      ST_DONE:     if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    mac_ctl      = '{start: 1'b0, mode: MAC_ROT};
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.req_type == REQ_CAPTURE || fc_in) begin
            div_start = 1'b1;
          end else if (in_ch.slow_mode) begin
            mac_ctl = '{start: 1'b1, mode: MAC_SCALE};
          end
        end
      end
      ST_LUT:     mac_ctl   = '{start: 1'b1, mode: MAC_ROT};
      ST_HUND:    div_start = 1'b1;
      ST_FWD_FIN: if (slow_r) mac_ctl = '{start: 1'b1, mode: MAC_SCALE};
      ST_DONE:    out_load  = !out_valid_r || out_ch.ready;
      default:    ;
    endcase
  end

  // ---------------- datapath combinational ----------------
  always_comb begin
    cd_sat  = (in_ch.heading_cdeg > FIELD_W'(HDG_MAX)) ? FIELD_W'(HDG_MAX)
                                                      : in_ch.heading_cdeg;
    // relative angle: a partial degree below the offset rounds toward zero
    hdg_deg = div_quot[DEG_W-1:0];
    wrap_up = (hdg_deg < offset_r) && (div_rem != '0);
    rel     = {1'b0, hdg_deg} - {1'b0, offset_r} + ANGLE_W'(wrap_up);
    deg_nxt = rel[ANGLE_W-1] ? DEG_W'(rel + ANGLE_W'(DEG_FULL)) : rel[DEG_W-1:0];
    cos_idx = (deg_r >= DEG_W'(DEG_3QUARTER)) ? deg_r - DEG_W'(DEG_3QUARTER)
                                              : deg_r + DEG_W'(DEG_QUARTER);
    // |P| * 100 as 64 + 32 + 4
    prod = (PROD_W'(p_mag_r) << 6) + (PROD_W'(p_mag_r) << 5) + (PROD_W'(p_mag_r) << 2);
    hund = HUND_W'(prod >> FWD_SHIFT);
    div_dvd = (state_r == ST_IDLE) ? DIV_W'(cd_sat)
                                   : {hund, {STICK_FRAC_BITS{1'b0}}};
    p_mag  = acc0[ACC_W-1] ? (~acc0 + 1'b1) : acc0;
    mplr_a = (state_r == ST_LUT) ? res0_r : slow_scale_r;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      offset_r     <= '0;
      slow_scale_r <= SLOW_SCALE_RST;
    end else begin
      state_r <= state_nxt;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == ST_ANGLE && req_r == REQ_CAPTURE) offset_r <= hdg_deg;
      if (cfg_we) slow_scale_r <= cfg_data;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_ch.req_type;
      slow_r <= in_ch.slow_mode;
      res0_r <= in_ch.stick_forward;
      res1_r <= in_ch.stick_strafe;
      res2_r <= in_ch.stick_turn;
    end
    case (state_r)
      ST_ANGLE: deg_r <= deg_nxt;
      ST_LUT: begin
        cos_r <= sin_q15(cos_idx);
        sin_r <= sin_q15(deg_r);
      end
      ST_FWD: begin
        p_neg_r <= acc0[ACC_W-1];
        p_mag_r <= p_mag;
        res1_r  <= shr0_sat(acc1);
      end
      ST_FWD_FIN: res0_r <= sat_mag(p_neg_r, ACC_W'(div_quot));
      ST_SLOW_FIN: begin
        res0_r <= shr0_sat(acc0);
        res1_r <= shr0_sat(acc1);
        res2_r <= shr0_sat(acc2);
      end
      default: ;
    endcase
    if (out_load) begin
      out_fwd_r <= res0_r;
      out_str_r <= res1_r;
      out_trn_r <= res2_r;
    end
  end

  // ---------------- units ----------------
  fcd_div100 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .last     (div_last),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  fcd_serial_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .mplr_a (mplr_a),
    .mplr_b (res1_r),
    .cos_v  (cos_r),
    .sin_v  (sin_r),
    .val0   (res0_r),
    .val1   (res1_r),
    .val2   (res2_r),
    .last   (mac_last),
    .acc0   (acc0),
    .acc1   (acc1),
    .acc2   (acc2)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_forward = out_fwd_r;
  assign out_ch.out_strafe  = out_str_r;
  assign out_ch.out_turn    = out_trn_r;

endmodule

### rtl/fcd_checker.sv
`timescale 1ns / 1ps

module fcd_checker import fcd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FIELD_W-1:0] out_forward,
  input logic [FIELD_W-1:0] out_strafe,
  input logic [FIELD_W-1:0] out_turn
);

  // result beat held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_forward) && $stable(out_strafe) && $stable(out_turn))
    else $error("result payload changed while stalled");

  // no stale result comes out of reset
  a_rst_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in work");

  // a result never appears on the cycle after an input beat
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised right after accept");

endmodule

bind field_centric_drive_rotator fcd_checker u_fcd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_forward (out_ch.out_forward),
  .out_strafe  (out_ch.out_strafe),
  .out_turn    (out_ch.out_turn)
);
